@@ design/sfd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the stereo feedback delay.
// Used by the ring, the controller, the datapath, the top level and the testbench; depends on nothing.
package sfd_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIX      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK = 2'd2;

   localparam logic [23:0] DELAY_RESET    = 24'd6144000;
   localparam logic [8:0]  MIX_RESET      = 9'd128;
   localparam logic [7:0]  FEEDBACK_RESET = 8'd128;
   localparam logic [8:0]  GAIN_ONE       = 9'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_INTERP,
      ST_WET,
      ST_MIX,
      ST_OUT
   } sfd_state_type;

   typedef struct packed {
      logic load;
      logic write;
      logic interp;
      logic wet;
      logic mix;
      logic out_load;
   } sfd_cmd_type;

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [26:0] x);
      logic signed [26:0] hi;
      logic signed [26:0] lo;
      hi = 27'sd8388607;
      lo = -27'sd8388608;
      if (x > hi) begin
         sat_sample = 24'sh7FFFFF;
      end else if (x < lo) begin
         sat_sample = 24'sh800000;
      end else begin
         sat_sample = x[SAMPLE_BITS-1:0];
      end
   endfunction

endpackage

@@ design/sfd_ring.sv @@
`timescale 1ns / 1ps
// Ring buffer memory for one channel: one write port and two registered read ports.
// Depends on sfd_pkg for the sample width.
module sfd_ring
   import sfd_pkg::*;
#(
   parameter int DEPTH = 65536
) (
   input  logic                              clock,
   input  logic                              we,
   input  logic [$clog2(DEPTH)-1:0]          waddr,
   input  logic signed [SAMPLE_BITS-1:0]     wdata,
   input  logic                              re,
   input  logic [$clog2(DEPTH)-1:0]          raddr0,
   input  logic [$clog2(DEPTH)-1:0]          raddr1,
   output logic signed [SAMPLE_BITS-1:0]     rdata0,
   output logic signed [SAMPLE_BITS-1:0]     rdata1
);

   logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata0 <= mem[raddr0];
         rdata1 <= mem[raddr1];
      end
   end

endmodule

@@ design/sfd_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the stereo feedback delay: feedback, ring write, interpolated read and mix.
// Depends on sfd_pkg and instantiates two sfd_ring memories.
module sfd_datapath
   import sfd_pkg::*;
#(
   parameter int RING_DEPTH = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sfd_cmd_type                    cmd,
   input  logic signed [SAMPLE_BITS-1:0]  left_in,
   input  logic signed [SAMPLE_BITS-1:0]  right_in,
   input  logic [23:0]                    delay_q8,
   input  logic [8:0]                     mix_q8,
   input  logic [7:0]                     feedback_q8,
   output logic signed [SAMPLE_BITS-1:0]  left_out,
   output logic signed [SAMPLE_BITS-1:0]  right_out
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int PW = ((AW > 17) ? AW : 17) + 1;
   localparam logic [32:0] DELAY_MAX = 33'((RING_DEPTH - 2) * 256);
   localparam logic [AW-1:0] POS_LAST = AW'(RING_DEPTH - 1);

   logic [AW-1:0]   wp_ff, wp_in;
   logic            wrap_ff, wrap_in;
   logic [AW-1:0]   idx0_ff, idx0_in;
   logic [AW-1:0]   idx1_ff, idx1_in;
   logic            valid0_ff, valid0_in;
   logic            valid1_ff, valid1_in;
   logic            hit0_ff, hit0_in;
   logic [7:0]      frac_ff;
   logic [8:0]      mixc_ff;

   logic [23:0]     delay_c;
   logic [16:0]     k0;
   logic [16:0]     k1;
   logic [PW-1:0]   diff0;
   logic [PW-1:0]   diff1;
   logic [PW-1:0]   pos0;
   logic [PW-1:0]   pos1;
   logic [8:0]      mixc;
   logic [8:0]      frac_inv;
   logic [8:0]      mix_inv;

   logic signed [SAMPLE_BITS-1:0] dry_ff    [2];
   logic signed [SAMPLE_BITS-1:0] prev_ff   [2];
   logic signed [32:0]            fbp_ff    [2];
   logic signed [SAMPLE_BITS-1:0] wr_ff     [2];
   logic signed [SAMPLE_BITS-1:0] rd0       [2];
   logic signed [SAMPLE_BITS-1:0] rd1       [2];
   logic signed [33:0]            pa_ff     [2];
   logic signed [33:0]            pb_ff     [2];
   logic signed [33:0]            pm_ff     [2];
   logic signed [33:0]            pd_ff     [2];
   logic signed [SAMPLE_BITS-1:0] out_ff    [2];

   logic signed [32:0]            fb_bias   [2];
   logic signed [25:0]            wr_sum    [2];
   logic signed [SAMPLE_BITS-1:0] s0        [2];
   logic signed [SAMPLE_BITS-1:0] s1        [2];
   logic signed [34:0]            wet_sum   [2];
   logic signed [34:0]            out_sum   [2];
   logic signed [SAMPLE_BITS-1:0] dry_in    [2];

   assign dry_in[0] = left_in;
   assign dry_in[1] = right_in;

   always_comb begin
      delay_c  = ({9'd0, delay_q8} > DELAY_MAX) ? DELAY_MAX[23:0] : delay_q8;
      k0       = {1'b0, delay_c[23:8]};
      k1       = k0 + 17'd1;
      diff0    = PW'(wp_ff) - PW'(k0);
      diff1    = PW'(wp_ff) - PW'(k1);
      pos0     = diff0[PW-1] ? (diff0 + PW'(RING_DEPTH)) : diff0;
      pos1     = diff1[PW-1] ? (diff1 + PW'(RING_DEPTH)) : diff1;
      idx0_in  = pos0[AW-1:0];
      idx1_in  = pos1[AW-1:0];
      valid0_in = wrap_ff || (idx0_in <= wp_ff);
      valid1_in = wrap_ff || (idx1_in <= wp_ff);
      hit0_in  = (idx0_in == wp_ff);
      mixc     = (mix_q8 > GAIN_ONE) ? GAIN_ONE : mix_q8;
      frac_inv = GAIN_ONE - {1'b0, frac_ff};
      mix_inv  = GAIN_ONE - mixc_ff;
      wp_in    = (wp_ff == POS_LAST) ? '0 : wp_ff + AW'(1);
      wrap_in  = wrap_ff || (wp_ff == POS_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         wrap_ff <= 1'b0;
      end else if (cmd.write) begin
         wp_ff   <= wp_in;
         wrap_ff <= wrap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx0_ff   <= idx0_in;
         idx1_ff   <= idx1_in;
         valid0_ff <= valid0_in;
         valid1_ff <= valid1_in;
         hit0_ff   <= hit0_in;
         frac_ff   <= delay_c[7:0];
         mixc_ff   <= mixc;
      end
   end

   for (genvar c = 0; c < 2; c++) begin : g_chan
      sfd_ring #(
         .DEPTH(RING_DEPTH)
      ) u_ring (
         .clock  (clock),
         .we     (cmd.write),
         .waddr  (wp_ff),
         .wdata  (sat_sample(27'(wr_sum[c]))),
         .re     (cmd.write),
         .raddr0 (idx0_ff),
         .raddr1 (idx1_ff),
         .rdata0 (rd0[c]),
         .rdata1 (rd1[c])
      );

      always_comb begin
         fb_bias[c] = fbp_ff[c] + 33'sd128;
         wr_sum[c]  = 26'(dry_ff[c]) + 26'($signed(fb_bias[c][32:8]));
         s0[c]      = hit0_ff ? wr_ff[c] : (valid0_ff ? rd0[c] : '0);
         s1[c]      = valid1_ff ? rd1[c] : '0;
         wet_sum[c] = 35'(pa_ff[c]) + 35'(pb_ff[c]) + 35'sd128;
         out_sum[c] = 35'(pm_ff[c]) + 35'(pd_ff[c]) + 35'sd128;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            prev_ff[c] <= '0;
         end else if (cmd.wet) begin
            prev_ff[c] <= wet_sum[c][31:8];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.load) begin
            dry_ff[c] <= dry_in[c];
            fbp_ff[c] <= prev_ff[c] * $signed({1'b0, feedback_q8});
         end
         if (cmd.write) begin
            wr_ff[c] <= sat_sample(27'(wr_sum[c]));
         end
         if (cmd.interp) begin
            pa_ff[c] <= s0[c] * $signed({1'b0, frac_inv});
            pb_ff[c] <= s1[c] * $signed({2'b0, frac_ff});
         end
         if (cmd.mix) begin
            pm_ff[c] <= prev_ff[c] * $signed({1'b0, mixc_ff});
            pd_ff[c] <= dry_ff[c] * $signed({1'b0, mix_inv});
         end
         if (cmd.out_load) begin
            out_ff[c] <= sat_sample(out_sum[c][34:8]);
         end
      end
   end

   assign left_out  = out_ff[0];
   assign right_out = out_ff[1];

endmodule

@@ design/sfd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the stereo feedback delay: sequences one request through the datapath.
// Depends on sfd_pkg for the state and command types.
module sfd_ctrl
   import sfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output sfd_cmd_type cmd
);

   sfd_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.interp = 1'b1;
            state_in   = ST_WET;
         end
         ST_WET: begin
            cmd.wet  = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = cmd.out_load || (out_valid_ff && !rsp_tready);
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

@@ design/stereo_feedback_delay_core.sv @@
`timescale 1ns / 1ps
// Top level of the stereo feedback delay: configuration registers, controller and datapath.
// Depends on sfd_pkg, sfd_ctrl and sfd_datapath.
//
//   Port group   Direction   Contents
//   req_         in          stereo input pair (left_in, right_in)
//   rsp_         out         stereo mixed pair (left_out, right_out)
//   csr_         in          register writes: delay_q8, mix_q8, feedback_q8
//
// The controller steps through ring write and read, interpolation, wet update, mix and
// output, reading both taps of each channel's ring in the write step, and takes no new
// request until the result is loaded into the output register.
// Reset is synchronous; the rings are not cleared, a wrap flag marks unwritten entries
// as zero, so requests are accepted in the first cycle after reset.
// A stalled result holds in the output register while the next request is processed.
module stereo_feedback_delay_core
   import sfd_pkg::*;
#(
   parameter int RING_DEPTH = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [47:0]               req_tdata,   // left_in [23:0], right_in [47:24]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [47:0]               rsp_tdata,   // left_out [23:0], right_out [47:24]
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [23:0] delay_ff;
   logic [8:0]  mix_ff;
   logic [7:0]  feedback_ff;

   sfd_cmd_type                   cmd;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= DELAY_RESET;
         mix_ff      <= MIX_RESET;
         feedback_ff <= FEEDBACK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DELAY:    delay_ff    <= csr_wdata;
            CSR_MIX:      mix_ff      <= csr_wdata[8:0];
            CSR_FEEDBACK: feedback_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   sfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sfd_datapath #(
      .RING_DEPTH(RING_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .left_in     (req_tdata[23:0]),
      .right_in    (req_tdata[47:24]),
      .delay_q8    (delay_ff),
      .mix_q8      (mix_ff),
      .feedback_q8 (feedback_ff),
      .left_out    (left_out),
      .right_out   (right_out)
   );

   assign rsp_tdata = {right_out, left_out};

   a_one_request_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in progress");

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 6))
      else $error("result appeared without a request six cycles earlier");

   a_single_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.write, cmd.interp, cmd.wet, cmd.mix, cmd.out_load}))
      else $error("controller issued more than one datapath command");

endmodule

@@ dv/stereo_feedback_delay_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stereo_feedback_delay_core: directed and random stereo requests
// over many register settings, checked against an in-bench echo predictor.
// Depends on sfd_pkg and the stereo_feedback_delay_core RTL.
module stereo_feedback_delay_core_tb;
   import sfd_pkg::*;

   localparam int          RING_SIZE    = 65536;
   localparam logic [23:0] DELAY_LIMIT  = 24'd16776704;
   localparam int          IDLE_LIMIT   = 4000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          HOLD_AT      = 400;
   localparam int          CALM_FROM    = 700;
   localparam int          CALM_TO      = 900;
   localparam int          RANDOM_SETS  = 10;
   localparam int          SET_ITEMS    = 138;

   typedef struct packed {
      logic signed [23:0] right;
      logic signed [23:0] left;
   } stereo_pair_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [47:0]               req_tdata = '0;   // left_in [23:0], right_in [47:24]
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [47:0]               rsp_tdata;        // left_out [23:0], right_out [47:24]
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_DELAY;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic signed [23:0] echo_ring [0:1][0:RING_SIZE-1];
   longint             prev_wet [0:1];
   logic [15:0]        ring_pos;
   logic [23:0]        echo_delay;
   logic [8:0]         echo_mix;
   logic [7:0]         echo_feedback;

   logic [47:0]     pending_pairs [$];
   stereo_pair_type expected_pairs [$];
   bit              req_took;
   bit              calm;
   bit              hold_done;
   int              hold_left;
   int              requests_done;
   int              results_seen;
   int              fail_count;
   int              idle_cycles;
   int              settings_used;

   stereo_feedback_delay_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic longint round_half_up(input longint x);
      return (x + 64'sd128) >>> 8;
   endfunction

   function automatic logic signed [23:0] clamp_sample(input longint x);
      if (x > 64'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (x < -64'sd8388608) begin
         return 24'sh800000;
      end
      return x[23:0];
   endfunction

   task automatic predict_echo(input logic [47:0] item);
      logic [23:0]     dclip;
      logic [8:0]      mix_eff;
      logic [15:0]     tap_near;
      logic [15:0]     tap_far;
      longint          frac;
      longint          mix_w;
      longint          dry;
      longint          fb;
      longint          s0;
      longint          s1;
      longint          wet;
      stereo_pair_type outs;
      dclip = (echo_delay > DELAY_LIMIT) ? DELAY_LIMIT : echo_delay;
      mix_eff = (echo_mix > GAIN_ONE) ? GAIN_ONE : echo_mix;
      frac = longint'(dclip[7:0]);
      mix_w = longint'(mix_eff);
      for (int ch = 0; ch < 2; ch++) begin
         dry = $signed(item[ch*24 +: 24]);
         fb = round_half_up(prev_wet[ch] * longint'(echo_feedback));
         echo_ring[ch][ring_pos] = clamp_sample(dry + fb);
         tap_near = ring_pos - dclip[23:8];
         tap_far = tap_near - 16'd1;
         s0 = echo_ring[ch][tap_near];
         s1 = echo_ring[ch][tap_far];
         wet = round_half_up(s0 * (256 - frac) + s1 * frac);
         prev_wet[ch] = wet;
         if (ch == 0) begin
            outs.left = clamp_sample(round_half_up(wet * mix_w + dry * (256 - mix_w)));
         end else begin
            outs.right = clamp_sample(round_half_up(wet * mix_w + dry * (256 - mix_w)));
         end
      end
      ring_pos = ring_pos + 16'd1;
      expected_pairs.push_back(outs);
   endtask

   // Request driver: holds the current request until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pending_pairs.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
            req_tdata <= pending_pairs.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver, with one long hold-off so that the block backs up.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 15);
      end
   end

   always @(posedge clock) begin
      stereo_pair_type want;
      req_took = !reset && req_tvalid && req_tready;
      idle_cycles = idle_cycles + 1;
      if (req_took) begin
         predict_echo(req_tdata);
         requests_done = requests_done + 1;
         calm = (requests_done >= CALM_FROM) && (requests_done < CALM_TO);
         idle_cycles = 0;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         idle_cycles = 0;
         if (expected_pairs.size() == 0) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
               $display("unexpected result %h with no request outstanding", rsp_tdata);
            end
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_tdata[23:0] !== want.left || rsp_tdata[47:24] !== want.right) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) begin
                  $display("result %0d: expected left %h right %h, got left %h right %h",
                           results_seen, want.left, want.right,
                           rsp_tdata[23:0], rsp_tdata[47:24]);
               end
            end
         end
         results_seen = results_seen + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("stereo_feedback_delay_core test failed");
         $finish;
      end
   end

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [23:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_DELAY) begin
         echo_delay = value;
      end else if (index == CSR_MIX) begin
         echo_mix = value[8:0];
      end else if (index == CSR_FEEDBACK) begin
         echo_feedback = value[7:0];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(input logic [23:0] delay, input logic [8:0] mix,
                                input logic [7:0] feedback);
      while (!(pending_pairs.size() == 0 && !req_tvalid && expected_pairs.size() == 0)) begin
         @(negedge clock);
      end
      repeat (12) @(negedge clock);
      write_register(CSR_DELAY, delay);
      write_register(CSR_MIX, {15'd0, mix});
      write_register(CSR_FEEDBACK, {16'd0, feedback});
      settings_used = settings_used + 1;
      @(posedge clock);
   endtask

   task automatic queue_pair(input logic [23:0] left, input logic [23:0] right);
      pending_pairs.push_back({right, left});
   endtask

   function automatic logic [23:0] random_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 24'($urandom());
         6: begin
            case ($urandom_range(0, 3))
               0: return 24'h7FFFFF;
               1: return 24'h800000;
               2: return 24'h000000;
               default: return 24'hFFFFFF;
            endcase
         end
         7: return 24'($signed($urandom_range(0, 2047)) - 1024);
         default: return {{2{$urandom_range(0, 1) == 1}}, 22'($urandom())};
      endcase
   endfunction

   function automatic logic [23:0] random_delay();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 24'($urandom_range(0, 200 * 256));
         6: return 24'($urandom_range(0, 255));
         7: return 24'd0;
         8: begin
            case ($urandom_range(0, 3))
               0: return DELAY_LIMIT;
               1: return 24'hFFFFFF;
               2: return DELAY_LIMIT - 24'd1;
               default: return DELAY_LIMIT + 24'd1;
            endcase
         end
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [8:0] random_mix();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 9'($urandom_range(0, 256));
         6: return 9'd0;
         7: return GAIN_ONE;
         8: return 9'($urandom_range(257, 511));
         default: return 9'($urandom());
      endcase
   endfunction

   function automatic logic [7:0] random_feedback();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom());
      endcase
   endfunction

   initial begin
      for (int ch = 0; ch < 2; ch++) begin
         prev_wet[ch] = 0;
         for (int i = 0; i < RING_SIZE; i++) begin
            echo_ring[ch][i] = '0;
         end
      end
      ring_pos = '0;
      echo_delay = DELAY_RESET;
      echo_mix = MIX_RESET;
      echo_feedback = FEEDBACK_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings after reset, extreme and alternating samples.
      queue_pair(24'h7FFFFF, 24'h800000);
      queue_pair(24'h800000, 24'h7FFFFF);
      queue_pair(24'h000000, 24'h000000);
      queue_pair(24'hFFFFFF, 24'h000001);
      queue_pair(24'h555555, 24'hAAAAAA);
      queue_pair(24'hAAAAAA, 24'h555555);

      // Zero delay, fully wet, strongest feedback: the ring value saturates.
      apply_setting(24'd0, GAIN_ONE, 8'd255);
      repeat (2) queue_pair(24'h7FFFFF, 24'h800000);
      repeat (2) queue_pair(24'h800000, 24'h7FFFFF);

      // Fractional delay of one and a half samples, fully dry.
      apply_setting(24'h000180, 9'd0, 8'd128);
      queue_pair(24'h400000, 24'hC00000);
      queue_pair(24'h000001, 24'hFFFFFF);
      queue_pair(24'h7FFFFF, 24'h7FFFFF);
      queue_pair(24'h800000, 24'h800000);
      queue_pair(24'h123456, 24'hEDCBA9);

      // Delay beyond the ring, mix above full scale, no feedback.
      apply_setting(24'hFFFFFF, 9'd511, 8'd0);
      queue_pair(24'h7FFFFF, 24'h800000);
      queue_pair(24'h0F0F0F, 24'hF0F0F0);
      queue_pair(24'h000000, 24'hFFFFFF);
      queue_pair(24'h800000, 24'h7FFFFF);

      apply_setting(DELAY_LIMIT, 9'd257, 8'd255);
      queue_pair(24'h7FFFFF, 24'h800000);
      queue_pair(24'h3C3C3C, 24'hC3C3C3);
      queue_pair(24'h800000, 24'h000000);

      for (int set = 0; set < RANDOM_SETS; set++) begin
         apply_setting(random_delay(), random_mix(), random_feedback());
         for (int n = 0; n < SET_ITEMS; n++) begin
            queue_pair(random_sample(), random_sample());
         end
      end

      apply_setting(DELAY_RESET, MIX_RESET, FEEDBACK_RESET);
      repeat (20) @(negedge clock);
      fail_count = fail_count + expected_pairs.size();
      $display("%0d stereo requests under %0d register settings, %0d results checked",
               requests_done, settings_used, results_seen);
      $display("failures: %0d, including a %0d-cycle receiver hold-off", fail_count,
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("stereo_feedback_delay_core test passed");
      end else begin
         $display("stereo_feedback_delay_core test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/sfd_pkg.sv
design/sfd_ring.sv
design/sfd_datapath.sv
design/sfd_ctrl.sv
design/stereo_feedback_delay_core.sv
dv/stereo_feedback_delay_core_tb.sv
